// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the splitter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define DFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define DFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// types and constants of the delimiter field splitter
// ----------------------------------------------------------------------------
package dfs_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPLITS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT  = 8'd3;

    // register reset values
    localparam logic [63:0] DELIM_BYTES_RST = 64'd47;
    localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;
    localparam logic [15:0] MAX_SPLITS_RST  = 16'd0;
    localparam logic [11:0] KEEP_LIMIT_RST  = 12'd0;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_SKIPPED = 1'b1;

    // widest window and counter the command record carries
    localparam int WIN_MAX    = 8;
    localparam int CNT_W_MAX  = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       is_empty;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] field_index;
        logic        field_end;
        logic        string_end;
        logic        status;
        logic [15:0] delimiter_count;
    } t_out_item;

    // one classified item: an optional result ahead of the push, then the
    // end-of-string work if the item closes the string
    typedef struct packed {
        logic                       has_pre;
        logic                       pre_fend;
        logic [7:0]                 pre_byte;
        logic [15:0]                pre_idx;
        logic                       last;
        logic                       skipped;
        logic                       held;
        logic [3:0]                 cnt;
        logic [WIN_MAX-1:0][7:0]    win;
        logic [15:0]                fn;
        logic [CNT_W_MAX-1:0]       fbc;
    } t_cmd;

endpackage

// File: rtl/dfs_front.sv
// ----------------------------------------------------------------------------
// dfs_front
// delimiter window, match compare and string counters; classifies each byte
// ----------------------------------------------------------------------------
module dfs_front #(
    parameter int MAX_DELIM_BYTES = 8,
    parameter int COUNT_BITS      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dfs_pkg::t_in_item i_item,
    input  logic              i_clear,
    input  logic [63:0]       i_delim_bytes,
    input  logic [3:0]        i_delim_len,
    input  logic [15:0]       i_max_splits,
    input  logic [11:0]       i_keep_limit,
    output logic              o_cmd_push,
    output dfs_pkg::t_cmd     o_cmd
);

    localparam int PW = $clog2(MAX_DELIM_BYTES + 1);
    localparam int SW = $clog2(MAX_DELIM_BYTES + 2);
    localparam int WB = MAX_DELIM_BYTES * 8;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [WB-1:0]         r_win;
    logic [PW-1:0]         r_pend;
    logic [SW-1:0]         r_seen;
    logic                  r_held;
    logic [COUNT_BITS-1:0] r_fbc;
    logic [COUNT_BITS-1:0] r_fn;

    logic [WB-1:0]         n_win;
    logic [PW-1:0]         n_pend;
    logic [SW-1:0]         n_seen;
    logic                  n_held;
    logic [COUNT_BITS-1:0] n_fbc;
    logic [COUNT_BITS-1:0] n_fn;

    logic [PW-1:0]         eff_len;
    logic                  step1;
    logic                  end1;
    logic                  shift1;
    logic                  pre_keep;
    logic [PW-1:0]         pend1;
    logic [WB-1:0]         win1;
    logic                  honor;
    logic                  match;
    logic                  skipped;

    always_comb begin
        if (i_delim_len == 4'd0) begin
            eff_len = PW'(1);
        end else if (i_delim_len > 4'(MAX_DELIM_BYTES)) begin
            eff_len = PW'(MAX_DELIM_BYTES);
        end else begin
            eff_len = PW'(i_delim_len);
        end
    end

    always_comb begin
        step1    = !i_item.is_empty && (r_pend == eff_len);
        end1     = step1 && r_held;
        shift1   = step1 && !r_held;
        pre_keep = (i_keep_limit == 12'd0) || (CW'(r_fbc) < CW'(i_keep_limit));

        // state after the oldest byte leaves or the held delimiter closes a field
        n_fn = end1 ? COUNT_BITS'(r_fn + 1'b1) : r_fn;
        if (end1) begin
            n_fbc = '0;
            pend1 = '0;
        end else if (shift1) begin
            n_fbc = (r_fbc == '1) ? r_fbc : COUNT_BITS'(r_fbc + 1'b1);
            pend1 = PW'(r_pend - 1'b1);
        end else begin
            n_fbc = r_fbc;
            pend1 = r_pend;
        end
        win1 = shift1 ? (r_win >> 8) : r_win;

        // push the new byte
        n_win  = win1;
        n_pend = pend1;
        n_seen = r_seen;
        if (!i_item.is_empty) begin
            for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
                if (PW'(i) == pend1) begin
                    n_win[i*8 +: 8] = i_item.data_byte;
                end
            end
            n_pend = PW'(pend1 + 1'b1);
            if (r_seen < SW'(MAX_DELIM_BYTES + 1)) begin
                n_seen = SW'(r_seen + 1'b1);
            end
        end

        // parallel window compare on the updated window
        match = 1'b1;
        for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            if ((PW'(i) < eff_len) && (n_win[i*8 +: 8] != i_delim_bytes[i*8 +: 8])) begin
                match = 1'b0;
            end
        end
        honor = (n_fn != '1) &&
                ((i_max_splits == 16'd0) || (CW'(n_fn) < CW'(i_max_splits)));
        if (!i_item.is_empty) begin
            n_held = (n_pend == eff_len) && honor && match;
        end else begin
            n_held = r_held;
        end

        skipped = (n_seen <= SW'(eff_len));
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.has_pre  = end1 || (shift1 && pre_keep);
        o_cmd.pre_fend = end1;
        o_cmd.pre_byte = r_win[7:0];
        o_cmd.pre_idx  = 16'(r_fn);
        o_cmd.last     = i_item.is_last;
        o_cmd.skipped  = skipped;
        o_cmd.held     = n_held;
        o_cmd.cnt      = 4'(n_pend);
        for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            o_cmd.win[i] = n_win[i*8 +: 8];
        end
        o_cmd.fn       = 16'(n_fn);
        o_cmd.fbc      = dfs_pkg::CNT_W_MAX'(n_fbc);
    end

    assign o_cmd_push = i_accept && !i_clear && (o_cmd.has_pre || i_item.is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pend <= '0;
            r_seen <= '0;
            r_held <= 1'b0;
            r_fbc  <= '0;
            r_fn   <= '0;
        end else if (i_accept) begin
            if (i_item.is_last) begin
                r_pend <= '0;
                r_seen <= '0;
                r_held <= 1'b0;
                r_fbc  <= '0;
                r_fn   <= '0;
            end else begin
                r_pend <= n_pend;
                r_seen <= n_seen;
                r_held <= n_held;
                r_fbc  <= n_fbc;
                r_fn   <= n_fn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// File: rtl/dfs_queue.sv
// ----------------------------------------------------------------------------
// dfs_queue
// short command queue between classifier and result sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  dfs_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_valid,
    output dfs_pkg::t_cmd o_head
);

    dfs_pkg::t_cmd                  r_mem [dfs_pkg::QUEUE_DEPTH];
    logic [dfs_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [dfs_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [dfs_pkg::QCNT_W-1:0]     r_count;

    assign o_full  = (r_count == dfs_pkg::QCNT_W'(dfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= dfs_pkg::QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_rd) begin
                r_rd_ptr <= dfs_pkg::QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_wr && !i_rd) begin
                r_count <= dfs_pkg::QCNT_W'(r_count + 1'b1);
            end else if (i_rd && !i_wr) begin
                r_count <= dfs_pkg::QCNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    `DFS_ASSERT_IMP(a_no_write_full, i_clk, i_rst_n, o_full, !i_wr, "queue written while full")
    `DFS_ASSERT_IMP(a_no_read_empty, i_clk, i_rst_n, !o_valid, !i_rd, "queue read while empty")

endmodule

// File: rtl/dfs_back.sv
// ----------------------------------------------------------------------------
// dfs_back
// expands queued commands into results, one per cycle unless pop stalls
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  dfs_pkg::t_cmd      i_q_head,
    output logic               o_q_rd,
    input  logic [11:0]        i_keep_limit,
    input  logic               i_pop,
    output logic               o_empty,
    output dfs_pkg::t_out_item o_out
);

    localparam logic [2:0] PH_PRE   = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_FEND  = 3'd2;
    localparam logic [2:0] PH_BYTES = 3'd3;
    localparam logic [2:0] PH_FINAL = 3'd4;

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  r_active;
    logic [2:0]            r_phase;
    logic [2:0]            r_pos;
    logic [COUNT_BITS-1:0] r_fbc;
    logic                  r_out_valid;
    dfs_pkg::t_out_item    r_out;

    logic [2:0]            n_phase;
    logic [2:0]            n_pos;
    logic [COUNT_BITS-1:0] n_fbc;

    logic [2:0]            flush_ph;
    logic [2:0]            cur_ph;
    logic [2:0]            cur_pos;
    logic [COUNT_BITS-1:0] cur_fbc;
    logic [15:0]           fin_idx;
    logic                  keep;
    logic                  last_byte;
    logic                  emit;
    logic                  done;
    logic                  ld_ok;
    logic                  go;
    dfs_pkg::t_out_item    res;

    always_comb begin
        if (i_q_head.skipped) begin
            flush_ph = PH_SKIP;
        end else if (i_q_head.held) begin
            flush_ph = PH_FEND;
        end else if (i_q_head.cnt != 4'd0) begin
            flush_ph = PH_BYTES;
        end else begin
            flush_ph = PH_FINAL;
        end

        if (r_active) begin
            cur_ph = r_phase;
        end else begin
            cur_ph = i_q_head.has_pre ? PH_PRE : flush_ph;
        end
        cur_pos   = r_active ? r_pos : 3'd0;
        cur_fbc   = (cur_pos == 3'd0) ? i_q_head.fbc[COUNT_BITS-1:0] : r_fbc;
        keep      = (i_keep_limit == 12'd0) || (CW'(cur_fbc) < CW'(i_keep_limit));
        last_byte = (i_q_head.cnt == 4'({1'b0, cur_pos} + 4'd1));
        fin_idx   = 16'(i_q_head.fn + 16'(i_q_head.held));

        res     = '0;
        emit    = 1'b0;
        done    = 1'b0;
        n_phase = cur_ph;
        n_pos   = 3'd0;
        n_fbc   = r_fbc;
        case (cur_ph)
            PH_PRE: begin
                emit            = 1'b1;
                res.field_index = i_q_head.pre_idx;
                if (i_q_head.pre_fend) begin
                    res.field_end = 1'b1;
                end else begin
                    res.out_byte   = i_q_head.pre_byte;
                    res.byte_valid = 1'b1;
                end
                if (i_q_head.last) begin
                    n_phase = flush_ph;
                end else begin
                    done = 1'b1;
                end
            end
            PH_SKIP: begin
                emit           = 1'b1;
                res.string_end = 1'b1;
                res.status     = dfs_pkg::STATUS_SKIPPED;
                done           = 1'b1;
            end
            PH_FEND: begin
                emit            = 1'b1;
                res.field_index = i_q_head.fn;
                res.field_end   = 1'b1;
                n_phase         = PH_FINAL;
            end
            PH_BYTES: begin
                emit            = keep;
                res.out_byte    = i_q_head.win[cur_pos];
                res.byte_valid  = 1'b1;
                res.field_index = i_q_head.fn;
                n_fbc           = (cur_fbc == '1) ? cur_fbc : COUNT_BITS'(cur_fbc + 1'b1);
                if (last_byte) begin
                    n_phase = PH_FINAL;
                end else begin
                    n_pos = 3'(cur_pos + 3'd1);
                end
            end
            PH_FINAL: begin
                emit                = 1'b1;
                res.field_index     = fin_idx;
                res.field_end       = 1'b1;
                res.string_end      = 1'b1;
                res.status          = dfs_pkg::STATUS_OK;
                res.delimiter_count = fin_idx;
                done                = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign ld_ok   = !r_out_valid || i_pop;
    assign go      = i_q_valid && (!emit || ld_ok);
    assign o_q_rd  = go && done;
    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= PH_PRE;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_active <= !done;
                r_phase  <= n_phase;
                r_pos    <= done ? 3'd0 : n_pos;
            end
            if (go && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_fbc <= n_fbc;
        end
        if (go && emit) begin
            r_out <= res;
        end
    end

    `DFS_ASSERT_IMP(a_active_has_cmd, i_clk, i_rst_n, r_active, i_q_valid, "sequencer mid-command with empty queue")
    `DFS_ASSERT_IMP(a_byte_not_fend, i_clk, i_rst_n, r_out_valid, !(r_out.byte_valid && r_out.field_end), "byte result marked as field end")

endmodule

// File: rtl/delimiter_field_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_field_splitter
// splits a byte string on a configurable 1 to 8 byte delimiter
//
//   channel   direction  handshake              payload
//   input     in         push / full            i_in_item  (t_in_item)
//   result    out        empty / pop            o_out_item (t_out_item)
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// a string byte is taken every cycle while full is low; each byte not ending
// a string gives at most one result: one transaction per cycle on both sides
// while pop keeps up; the byte that ends a string expands into up to
// delimiter length + 2 results, one per cycle by the result sequencer
// a four-entry command queue separates classification from result issue;
// full rises only when that queue is full
// reset is synchronous and active low, clears control state; no clearing pass
// ----------------------------------------------------------------------------
module delimiter_field_splitter #(
    parameter int MAX_DELIM_BYTES = 8,
    parameter int COUNT_BITS      = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input queue side
    input  logic                           push,
    output logic                           full,
    input  dfs_pkg::t_in_item              i_in_item,
    // result queue side
    output logic                           empty,
    input  logic                           pop,
    output dfs_pkg::t_out_item             o_out_item,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);

    // configuration registers
    logic [63:0] r_delim_bytes;
    logic [3:0]  r_delim_len;
    logic [15:0] r_max_splits;
    logic [11:0] r_keep_limit;

    logic          cfg_we;
    logic          in_accept;
    logic          q_full;
    logic          q_valid;
    logic          q_rd;
    logic          cmd_push;
    dfs_pkg::t_cmd cmd;
    dfs_pkg::t_cmd q_head;

    // writes are always taken; any write also drops a partial string
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= dfs_pkg::DELIM_BYTES_RST;
            r_delim_len   <= dfs_pkg::DELIM_LEN_RST;
            r_max_splits  <= dfs_pkg::MAX_SPLITS_RST;
            r_keep_limit  <= dfs_pkg::KEEP_LIMIT_RST;
        end else if (cfg_we) begin
            case (i_cfg_index)
                dfs_pkg::CFG_DELIM_BYTES: r_delim_bytes <= i_cfg_data;
                dfs_pkg::CFG_DELIM_LEN:   r_delim_len   <= i_cfg_data[3:0];
                dfs_pkg::CFG_MAX_SPLITS:  r_max_splits  <= i_cfg_data[15:0];
                dfs_pkg::CFG_KEEP_LIMIT:  r_keep_limit  <= i_cfg_data[11:0];
                default: begin
                    // unknown index: only the string reset applies
                end
            endcase
        end
    end

    // input transaction completes when push meets a free queue slot
    assign full      = q_full;
    assign in_accept = push && !q_full;

    // front: window, compare, counters
    dfs_front #(
        .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
        .COUNT_BITS      (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_item        (i_in_item),
        .i_clear       (cfg_we),
        .i_delim_bytes (r_delim_bytes),
        .i_delim_len   (r_delim_len),
        .i_max_splits  (r_max_splits),
        .i_keep_limit  (r_keep_limit),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd)
    );

    // decoupling queue of classified items
    dfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_push),
        .i_wr_cmd (cmd),
        .i_rd     (q_rd),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    // back: result sequencer with output register
    dfs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_rd       (q_rd),
        .i_keep_limit (r_keep_limit),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out        (o_out_item)
    );

endmodule

// File: dv/delimiter_field_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimiter_field_splitter_test
// self-checking bench for the delimiter field splitter: strings are pushed
// byte by byte under random idling on both queue sides, every accepted byte
// runs through a behavioral splitter that builds the expected field
// transactions, and each popped result is checked field by field
// ----------------------------------------------------------------------------
module delimiter_field_splitter_test;

    localparam int unsigned FIELD_COUNT_MAX = 65535;
    // command queue plus a worst-case string end still in flight
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [dfs_pkg::CFG_IDX_W-1:0] CFG_PAST_LAST = dfs_pkg::CFG_KEEP_LIMIT + 8'd1;
    localparam logic [dfs_pkg::CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;

    // dut ports; the inputs are at known values from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    dfs_pkg::t_in_item             i_in_item = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    dfs_pkg::t_out_item            o_out_item;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [dfs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]                   i_cfg_data = '0;

    delimiter_field_splitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // splitter shadow: register copy and per-string state
    // ------------------------------------------------------------------
    logic [63:0]  cfg_delim;
    logic [3:0]   cfg_dlen;
    logic [15:0]  cfg_max_splits;
    logic [11:0]  cfg_keep;

    logic [7:0]   win_bytes [dfs_pkg::WIN_MAX];
    int unsigned  held_cnt;      // bytes held while a delimiter may still match
    int unsigned  seen_cnt;      // string length so far, saturates at WIN_MAX + 1
    bit           match_held;    // full window is a delimiter we will honor
    int unsigned  fld_bytes;     // bytes of the current field, saturating
    int unsigned  fld_num;       // current field index = honored delimiters

    dfs_pkg::t_out_item due_results[$];   // field transactions still to be popped
    dfs_pkg::t_in_item  stream_items[$];  // string bytes waiting for the driver

    int unsigned  items_queued;
    int unsigned  items_taken;
    int unsigned  string_items;     // items the block does not ignore
    int unsigned  fail_count;
    bit           in_bursts;
    bit           out_bursts;

    function automatic int unsigned active_len();
        if (cfg_dlen == 4'd0) return 1;
        if (cfg_dlen > dfs_pkg::WIN_MAX) return dfs_pkg::WIN_MAX;
        return 32'(cfg_dlen);
    endfunction

    function automatic void clear_string();
        held_cnt   = 0;
        seen_cnt   = 0;
        match_held = 1'b0;
        fld_bytes  = 0;
        fld_num    = 0;
    endfunction

    function automatic void post_result(logic [7:0] b, logic bv, logic [15:0] idx,
                                        logic fe, logic se, logic st, logic [15:0] dc);
        dfs_pkg::t_out_item r;
        r.out_byte        = b;
        r.byte_valid      = bv;
        r.field_index     = idx;
        r.field_end       = fe;
        r.string_end      = se;
        r.status          = st;
        r.delimiter_count = dc;
        due_results.push_back(r);
    endfunction

    // oldest held byte leaves the window as a field byte, unless past the keep limit
    function automatic void release_oldest();
        int i;
        if (held_cnt == 0) return;
        if (cfg_keep == 12'd0 || fld_bytes < cfg_keep)
            post_result(win_bytes[0], 1'b1, 16'(fld_num), 1'b0, 1'b0,
                        dfs_pkg::STATUS_OK, 16'd0);
        if (fld_bytes < FIELD_COUNT_MAX) fld_bytes++;
        for (i = 0; i < dfs_pkg::WIN_MAX - 1; i++) win_bytes[i] = win_bytes[i + 1];
        held_cnt--;
    endfunction

    // a honored delimiter closes the field; its bytes are consumed
    function automatic void close_field();
        post_result(8'h00, 1'b0, 16'(fld_num), 1'b1, 1'b0, dfs_pkg::STATUS_OK, 16'd0);
        fld_num++;
        fld_bytes = 0;
        held_cnt  = 0;
    endfunction

    function automatic void split_item(dfs_pkg::t_in_item it);
        int unsigned dlen;
        int unsigned i;
        bit          hit;
        dlen = active_len();
        if (!it.is_empty) begin
            if (held_cnt >= dlen) begin
                if (match_held) close_field();
                else release_oldest();
            end
            match_held = 1'b0;
            if (held_cnt < dfs_pkg::WIN_MAX) begin
                win_bytes[held_cnt] = it.data_byte;
                held_cnt++;
            end
            if (seen_cnt < dfs_pkg::WIN_MAX + 1) seen_cnt++;
            if (held_cnt == dlen) begin
                // honor only below the split cap and the field counter ceiling
                hit = (fld_num < FIELD_COUNT_MAX) &&
                      (cfg_max_splits == 16'd0 || fld_num < cfg_max_splits);
                for (i = 0; i < dlen; i++)
                    if (win_bytes[i] != cfg_delim[8*i +: 8]) hit = 1'b0;
                match_held = hit;
            end
        end
        if (!it.is_last) return;
        // string no longer than the delimiter: one skipped transaction only
        if (seen_cnt <= dlen) begin
            post_result(8'h00, 1'b0, 16'd0, 1'b0, 1'b1, dfs_pkg::STATUS_SKIPPED, 16'd0);
            clear_string();
            return;
        end
        if (held_cnt >= dlen) begin
            if (match_held) close_field();
            else release_oldest();
        end
        while (held_cnt > 0) release_oldest();
        // last field end and string end share one transaction
        post_result(8'h00, 1'b0, 16'(fld_num), 1'b1, 1'b1, dfs_pkg::STATUS_OK,
                    16'(fld_num));
        clear_string();
    endfunction

    // ------------------------------------------------------------------
    // input driver: one string byte per transaction, random idle bursts
    // ------------------------------------------------------------------
    int in_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            in_gap = 0;
        end else begin
            if (push && !full) begin
                split_item(i_in_item);
                items_taken++;
            end
            // hold the current transaction while the block is full
            if (!push || !full) begin
                if (in_gap > 0) begin
                    in_gap--;
                    push <= 1'b0;
                end else if (in_bursts && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 8);
                    push   <= 1'b0;
                end else if (stream_items.size() > 0) begin
                    push      <= 1'b1;
                    i_in_item <= stream_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: check each popped transaction against the oldest
    // expectation, random pop stalls
    // ------------------------------------------------------------------
    int                 out_gap;
    dfs_pkg::t_out_item want;

    function automatic string item_text(dfs_pkg::t_out_item r);
        return $sformatf("byte=%h bv=%b idx=%0d fend=%b send=%b st=%b dcnt=%0d",
                         r.out_byte, r.byte_valid, r.field_index, r.field_end,
                         r.string_end, r.status, r.delimiter_count);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            out_gap = 0;
        end else begin
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("ERROR: unexpected result %s", item_text(o_out_item));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item.out_byte        !== want.out_byte        ||
                        o_out_item.byte_valid      !== want.byte_valid      ||
                        o_out_item.field_index     !== want.field_index     ||
                        o_out_item.field_end       !== want.field_end       ||
                        o_out_item.string_end      !== want.string_end      ||
                        o_out_item.status          !== want.status          ||
                        o_out_item.delimiter_count !== want.delimiter_count) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected %s", item_text(want));
                            $display("  actual   %s", item_text(o_out_item));
                        end
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                pop <= 1'b0;
            end else if (out_bursts && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 8);
                pop     <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [7:0] b, input logic last, input logic no_byte);
        dfs_pkg::t_in_item it;
        it.data_byte = b;
        it.is_last   = last;
        it.is_empty  = no_byte;
        stream_items.push_back(it);
        items_queued++;
        if (!no_byte || last) string_items++;
    endtask

    task automatic queue_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) queue_item(s[k], k == s.len() - 1, 1'b0);
    endtask

    // random string rich in whole and partial delimiters; open strings are
    // left for the next register write to discard
    task automatic queue_string(input bit close);
        logic [7:0]  text[$];
        int unsigned dlen, goal, cut, j, k;
        bit          empty_end;
        dlen      = active_len();
        goal      = $urandom_range(0, 3 * dlen + 6);
        empty_end = ($urandom_range(0, 6) == 0);
        while (text.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (j = 0; j < dlen; j++) text.push_back(cfg_delim[8*j +: 8]);
                end
                3: begin
                    cut = $urandom_range(1, dlen);
                    for (j = 0; j < cut; j++) text.push_back(cfg_delim[8*j +: 8]);
                end
                4, 5, 6, 7: begin
                    j = $urandom_range(0, dlen - 1);
                    text.push_back(cfg_delim[8*j +: 8]);
                end
                default: begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        for (k = 0; k < text.size(); k++) begin
            // stray byte-less item in mid string, ignored by the block
            if ($urandom_range(0, 19) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            queue_item(text[k], close && !empty_end && k == text.size() - 1, 1'b0);
        end
        if (close && (empty_end || text.size() == 0))
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    // all bytes taken, all results popped, then let in-flight work drain
    task automatic wait_idle();
        do @(posedge i_clk);
        while (items_taken != items_queued || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dfs_pkg::CFG_DELIM_BYTES: cfg_delim      = data;
            dfs_pkg::CFG_DELIM_LEN:   cfg_dlen       = data[3:0];
            dfs_pkg::CFG_MAX_SPLITS:  cfg_max_splits = data[15:0];
            dfs_pkg::CFG_KEEP_LIMIT:  cfg_keep       = data[11:0];
            default: ;
        endcase
        // any write drops the string in progress
        clear_string();
    endtask

    // unused upper data bits carry junk on purpose
    task automatic load_settings(input logic [63:0] delim, input logic [3:0] len,
                                 input logic [15:0] splits, input logic [11:0] keep);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        wait_idle();
        write_reg(dfs_pkg::CFG_DELIM_BYTES, delim);
        write_reg(dfs_pkg::CFG_DELIM_LEN, {junk[63:4], len});
        write_reg(dfs_pkg::CFG_MAX_SPLITS, {junk[63:16], splits});
        write_reg(dfs_pkg::CFG_KEEP_LIMIT, {junk[63:12], keep});
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [63:0] pick_delim;
    logic [3:0]  pick_len;
    logic [15:0] pick_splits;
    logic [11:0] pick_keep;
    int unsigned phase_start, random_base, b, n;

    initial begin
        cfg_delim      = dfs_pkg::DELIM_BYTES_RST;
        cfg_dlen       = dfs_pkg::DELIM_LEN_RST;
        cfg_max_splits = dfs_pkg::MAX_SPLITS_RST;
        cfg_keep       = dfs_pkg::KEEP_LIMIT_RST;
        for (b = 0; b < dfs_pkg::WIN_MAX; b++) win_bytes[b] = 8'h00;
        clear_string();
        items_queued = 0;
        items_taken  = 0;
        string_items = 0;
        fail_count   = 0;
        in_bursts    = 1'b1;
        out_bursts   = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: '/' delimiter of one byte
        queue_item(8'h00, 1'b1, 1'b1);          // empty string, skipped
        queue_text("/");                        // not longer than delimiter
        queue_item(8'h00, 1'b0, 1'b0);          // byte extremes
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_text("a/b");
        queue_text("//");                       // back-to-back delimiters
        queue_item("a", 1'b0, 1'b0);
        queue_item(8'hA5, 1'b0, 1'b1);          // byte-less item mid string
        queue_text("/");                        // delimiter ends string, empty last field
        queue_item("a", 1'b0, 1'b0);
        queue_item("b", 1'b0, 1'b0);
        queue_item(8'h5A, 1'b1, 1'b1);          // byte-less last item closes string

        // two-byte delimiter "xy", one split, one byte kept per field
        load_settings(64'h7978, 4'd2, 16'd1, 12'd1);
        queue_text("abxyxycd");

        // zero length acts as one; open string then writes past the register list
        load_settings({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF_FF00 | 64'h61,
                      4'd0, 16'd0, 12'd0);
        phase_start = string_items;
        while (string_items - phase_start < 20) queue_string(1'b1);
        queue_string(1'b0);
        queue_item("a", 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_PAST_LAST, {$urandom(), $urandom()});
        queue_string(1'b0);
        queue_item("a", 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_TOP_INDEX, {$urandom(), $urandom()});
        queue_string(1'b1);

        // oversize length acts as eight, top split cap, top keep limit
        load_settings(64'h6162_6162_6261_6261, 4'd15, 16'hFFFF, 12'hFFF);
        phase_start = string_items;
        while (string_items - phase_start < 15) queue_string(1'b1);

        // all-ones delimiter of eight bytes
        load_settings(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'd0, 12'd2);
        phase_start = string_items;
        while (string_items - phase_start < 15) queue_string(1'b1);

        // random settings, small lengths and caps most of the time
        random_base = string_items;
        while (string_items - random_base < 80) begin
            pick_len = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 4))
                                                   : 4'($urandom_range(0, 15));
            for (b = 0; b < 8; b++)
                pick_delim[8*b +: 8] = ($urandom_range(0, 3) == 0)
                                       ? 8'($urandom_range(0, 255))
                                       : 8'h61 + 8'($urandom_range(0, 1));
            n = $urandom_range(0, 9);
            pick_splits = (n < 5) ? 16'd0 : (n < 9) ? 16'($urandom_range(1, 3)) : 16'hFFFF;
            n = $urandom_range(0, 9);
            pick_keep = (n < 5) ? 12'd0 : (n < 9) ? 12'($urandom_range(1, 4)) : 12'hFFF;
            load_settings(pick_delim, pick_len, pick_splits, pick_keep);
            in_bursts  = ($urandom_range(0, 3) != 0);
            out_bursts = ($urandom_range(0, 3) != 0);
            phase_start = string_items;
            while (string_items - phase_start < 20) queue_string(1'b1);
            if ($urandom_range(0, 2) == 0) queue_string(1'b0);
        end

        // last part, no idling: zero-byte delimiter, top keep limit
        in_bursts  = 1'b0;
        out_bursts = 1'b0;
        load_settings(64'h0, 4'd1, 16'd0, 12'hFFF);
        phase_start = string_items;
        while (string_items - phase_start < 20) queue_string(1'b1);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dfs_pkg.sv
rtl/dfs_front.sv
rtl/dfs_queue.sv
rtl/dfs_back.sv
rtl/delimiter_field_splitter.sv
dv/delimiter_field_splitter_test.sv
